// ===== design/loas_pkg.sv =====
// Shared types and constants for the lidar obstacle-avoid steering block.
// Used by the front, queue, back and top-level modules; no dependencies.
`timescale 1ns / 1ps

package loas_pkg;

	// Default range field width in bits
	localparam int RANGE_WIDTH_DEF = 12;

	// Configuration register indexes and reset values
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 10;
	localparam logic [CFG_ADDR_W-1:0] REG_SEARCH_PERIOD = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_SIDE_MARGIN   = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_BACKOFF_SPEED = 2'd2;
	localparam logic [7:0] SEARCH_PERIOD_RST = 8'd80;
	localparam logic [9:0] SIDE_MARGIN_RST   = 10'd120;
	localparam logic [7:0] BACKOFF_SPEED_RST = 8'd60;

	// Hold times in milliseconds
	localparam logic [9:0] HOLD_STOP      = 10'd150;
	localparam logic [9:0] HOLD_BACK      = 10'd350;
	localparam logic [9:0] HOLD_BACK_LONG = 10'd800;

	// Output packing: action, turn_degrees, motor_speed, hold_ms
	localparam int OUT_FIELDS_W = 2 + 9 + 8 + 10;
	localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD      = OUT_W - OUT_FIELDS_W;

	// Plan queue depth and command index width (up to seven commands per tick)
	localparam int QUEUE_DEPTH = 4;
	localparam int CMD_IDX_W   = 3;

	// Command action codes
	typedef enum logic [1:0] {
		ACT_TURN = 2'd0,
		ACT_FWD  = 2'd1,
		ACT_REV  = 2'd2,
		ACT_STOP = 2'd3
	} act_t;

	// Kind of main decision for a tick
	typedef enum logic [1:0] {
		KIND_TURN   = 2'd0,
		KIND_ESCAPE = 2'd1,
		KIND_FWD    = 2'd2
	} kind_t;

	// Classified tick handed from front to back
	typedef struct packed {
		logic               has_search;
		logic signed [8:0]  search_deg;
		kind_t              kind;
		logic signed [8:0]  deg;
		logic [7:0]         spd;
		logic               long_esc;
	} plan_t;

endpackage

// ===== design/loas_front.sv =====
// Front part: configuration registers, tick/search/escape state and tick
// classification into a plan. Depends on loas_pkg.
`timescale 1ns / 1ps

module loas_front #(
	parameter int RANGE_WIDTH = loas_pkg::RANGE_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [loas_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [loas_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	input  logic [RANGE_WIDTH-1:0]           range_middle,
	input  logic [RANGE_WIDTH-1:0]           range_left,
	input  logic [RANGE_WIDTH-1:0]           range_right,
	input  logic                             full,
	output logic                             in_ready,
	output logic                             push,
	output loas_pkg::plan_t                  plan
);

	localparam int SUM_W = (RANGE_WIDTH > 10 ? RANGE_WIDTH : 10) + 1;
	localparam logic [RANGE_WIDTH-1:0] R220 = RANGE_WIDTH'(220);
	localparam logic [RANGE_WIDTH-1:0] R250 = RANGE_WIDTH'(250);
	localparam logic [RANGE_WIDTH-1:0] R280 = RANGE_WIDTH'(280);
	localparam logic [RANGE_WIDTH-1:0] R300 = RANGE_WIDTH'(300);
	localparam logic [RANGE_WIDTH-1:0] R320 = RANGE_WIDTH'(320);
	localparam logic [RANGE_WIDTH-1:0] R350 = RANGE_WIDTH'(350);
	localparam logic [RANGE_WIDTH-1:0] R400 = RANGE_WIDTH'(400);
	localparam logic [RANGE_WIDTH-1:0] R450 = RANGE_WIDTH'(450);
	localparam logic [RANGE_WIDTH-1:0] R500 = RANGE_WIDTH'(500);

	logic [7:0] search_period_q;
	logic [9:0] side_margin_q;
	logic [7:0] backoff_speed_q;
	logic [7:0] tick_count_q;
	logic [2:0] search_step_q;
	logic [1:0] escape_step_q;

	logic [8:0]        next_tick;
	logic              fire;
	logic signed [8:0] search_deg;
	logic [2:0]        search_step_adv;
	logic              band25, band45, band65, close_hit;
	logic [SUM_W-1:0]  l_ext, r_ext, margin_ext;
	logic              l_clear, r_clear, l_ge_r;
	logic signed [8:0] band_mag, side_deg, esc_mag;
	logic [7:0]        fwd_spd;

	assign in_ready = !full;
	assign push     = in_valid && !full;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_period_q <= loas_pkg::SEARCH_PERIOD_RST;
			side_margin_q   <= loas_pkg::SIDE_MARGIN_RST;
			backoff_speed_q <= loas_pkg::BACKOFF_SPEED_RST;
		end else if (cfg_valid) begin
			case (cfg_addr)
				loas_pkg::REG_SEARCH_PERIOD: search_period_q <= cfg_data[7:0];
				loas_pkg::REG_SIDE_MARGIN:   side_margin_q   <= cfg_data;
				loas_pkg::REG_BACKOFF_SPEED: backoff_speed_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Search counter and pattern step
	always_comb begin
		next_tick = {1'b0, tick_count_q} + 9'd1;
		fire      = next_tick > {1'b0, search_period_q};
		case (search_step_q)
			3'd0, 3'd1: search_deg = 9'sd15;
			3'd2:       search_deg = 9'sd30;
			3'd3:       search_deg = 9'sd45;
			3'd4:       search_deg = 9'sd60;
			default:    search_deg = -9'sd165;
		endcase
		search_step_adv = (search_step_q < 3'd5) ? search_step_q + 3'd1 : 3'd0;
	end

	// Classify the forward range and pick the side
	always_comb begin
		band25    = (range_middle > R280) && (range_middle < R320);
		band45    = (range_middle > R250) && (range_middle < R280);
		band65    = (range_middle > R220) && (range_middle < R250);
		close_hit = (range_middle != '0) && (range_middle <= R220);

		l_ext      = SUM_W'(range_left);
		r_ext      = SUM_W'(range_right);
		margin_ext = SUM_W'(side_margin_q);
		l_clear    = l_ext > r_ext + margin_ext;
		r_clear    = r_ext > l_ext + margin_ext;
		l_ge_r     = range_left >= range_right;

		if (band25)      band_mag = 9'sd25;
		else if (band45) band_mag = 9'sd45;
		else             band_mag = 9'sd65;

		if (l_clear)      side_deg = -band_mag;
		else if (r_clear) side_deg = band_mag;
		else              side_deg = l_ge_r ? -band_mag : band_mag;

		case (escape_step_q)
			2'd0:    esc_mag = 9'sd60;
			2'd1:    esc_mag = 9'sd100;
			2'd2:    esc_mag = 9'sd145;
			default: esc_mag = 9'sd180;
		endcase

		if (range_middle > R500 && range_left > R350 && range_right > R350)
			fwd_spd = 8'd155;
		else if (range_middle > R450 && range_left > R300 && range_right > R300)
			fwd_spd = 8'd130;
		else if (range_middle > R400) fwd_spd = 8'd120;
		else if (range_middle > R350) fwd_spd = 8'd100;
		else if (range_middle > R300) fwd_spd = 8'd90;
		else                          fwd_spd = 8'd70;
	end

	// Build the plan for this tick
	always_comb begin
		plan.has_search = fire;
		plan.search_deg = search_deg;
		plan.long_esc   = 1'b0;
		plan.spd        = 8'd0;
		plan.deg        = 9'sd0;
		if (band25 || band45 || band65) begin
			plan.kind = loas_pkg::KIND_TURN;
			plan.deg  = side_deg;
		end else if (close_hit) begin
			plan.kind     = loas_pkg::KIND_ESCAPE;
			plan.spd      = backoff_speed_q;
			plan.long_esc = (escape_step_q == 2'd3);
			if (escape_step_q == 2'd3)       plan.deg = esc_mag;
			else if (range_left > range_right) plan.deg = -esc_mag;
			else                             plan.deg = esc_mag;
		end else begin
			plan.kind = loas_pkg::KIND_FWD;
			plan.spd  = fwd_spd;
		end
	end

	// Advance tick state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q  <= 8'd0;
			search_step_q <= 3'd0;
			escape_step_q <= 2'd0;
		end else if (push) begin
			if (close_hit && !(band25 || band45 || band65)) begin
				tick_count_q  <= 8'd0;
				search_step_q <= 3'd0;
				escape_step_q <= escape_step_q + 2'd1;
			end else begin
				tick_count_q  <= fire ? 8'd0 : next_tick[7:0];
				search_step_q <= fire ? search_step_adv : search_step_q;
				if (!(band25 || band45 || band65)) escape_step_q <= 2'd0;
			end
		end
	end

endmodule

// ===== design/loas_queue.sv =====
// Short plan queue between front and back so each side stalls on its own.
// Depends on loas_pkg.
`timescale 1ns / 1ps

module loas_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  loas_pkg::plan_t push_plan,
	input  logic            pop,
	output logic            full,
	output logic            empty,
	output loas_pkg::plan_t head
);

	localparam int DEPTH = loas_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	loas_pkg::plan_t  entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	// Store pushed plans
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_plan;
	end

	// Move pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/loas_back.sv =====
// Back part: expands each queued plan into its command sequence, one command
// per cycle while the output is not stalled, into an output register. Depends on loas_pkg.
`timescale 1ns / 1ps

module loas_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    empty,
	input  loas_pkg::plan_t         head,
	output logic                    pop,
	input  logic                    out_ready,
	output logic                    out_valid,
	output loas_pkg::act_t          out_act,
	output logic signed [8:0]       out_deg,
	output logic [7:0]              out_spd,
	output logic [9:0]              out_hold,
	output logic                    out_last
);

	localparam int IW = loas_pkg::CMD_IDX_W;

	logic [IW-1:0]     k_q;
	logic [IW-1:0]     j;
	logic [IW-1:0]     cnt;
	logic              in_search, last, advance, load;
	loas_pkg::act_t    act;
	logic signed [8:0] deg;
	logic [7:0]        spd;
	logic [9:0]        hold;

	// Select the command at the current position
	always_comb begin
		in_search = head.has_search && (k_q == '0);
		j         = k_q - IW'(head.has_search);
		case (head.kind)
			loas_pkg::KIND_ESCAPE: cnt = head.long_esc ? IW'(6) : IW'(4);
			default:               cnt = IW'(1);
		endcase
		last = !in_search && (j == cnt - IW'(1));

		act  = loas_pkg::ACT_TURN;
		deg  = 9'sd0;
		spd  = 8'd0;
		hold = 10'd0;
		if (in_search) begin
			deg = head.search_deg;
		end else begin
			case (head.kind)
				loas_pkg::KIND_TURN: deg = head.deg;
				loas_pkg::KIND_FWD: begin
					act = loas_pkg::ACT_FWD;
					spd = head.spd;
				end
				loas_pkg::KIND_ESCAPE: begin
					case (j)
						IW'(0), IW'(2), IW'(4): begin
							act  = loas_pkg::ACT_STOP;
							hold = loas_pkg::HOLD_STOP;
						end
						IW'(1): begin
							act  = loas_pkg::ACT_REV;
							spd  = head.spd;
							hold = loas_pkg::HOLD_BACK;
						end
						IW'(3): begin
							if (head.long_esc) begin
								act  = loas_pkg::ACT_REV;
								spd  = head.spd;
								hold = loas_pkg::HOLD_BACK_LONG;
							end else begin
								deg = head.deg;
							end
						end
						default: deg = head.deg;
					endcase
				end
				default: ;
			endcase
		end
	end

	assign advance = !out_valid || out_ready;
	assign load    = advance && !empty;
	assign pop     = load && last;

	// Step through the plan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q       <= '0;
			out_valid <= 1'b0;
		end else begin
			if (advance) out_valid <= !empty;
			if (load)    k_q <= last ? '0 : k_q + IW'(1);
		end
	end

	// Hold the command until the transaction completes
	always_ff @(posedge clk) begin
		if (load) begin
			out_act  <= act;
			out_deg  <= deg;
			out_spd  <= spd;
			out_hold <= hold;
			out_last <= last;
		end
	end

endmodule

// ===== design/lidar_obstacle_avoid_steering.sv =====
// Top level of the lidar obstacle-avoid steering block.
// Instantiates loas_front, loas_queue and loas_back; depends on loas_pkg.
//
// Usage:
//  - s_* channel: one navigation tick per transaction. s_tdata carries
//    range_middle, range_left, range_right, RANGE_WIDTH bits each.
//  - cfg_* channel: register writes (0 search_period, 1 side_margin,
//    2 backoff_speed); cfg_ready is always high, other indexes are dropped.
//  - m_* channel: one steering command per transaction; m_tlast marks the
//    last command of a tick. A tick yields 1 to 7 commands.
//  - The first command of a tick passes through the plan queue and then
//    the output register on its way to m_tdata.
//  - Throughput: the back sequencer emits one command per cycle while
//    m_tready is high. The front accepts a tick every cycle while the
//    four-entry plan queue has room.
//  - Reset: control state clears at once, configuration registers take
//    their defaults; no clearing pass.
//  - Stall: when m_tready is low the current command holds; the queue
//    keeps absorbing ticks until full, then s_tready drops.
`timescale 1ns / 1ps

module lidar_obstacle_avoid_steering #(
	parameter int RANGE_WIDTH = loas_pkg::RANGE_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [loas_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [loas_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// range_middle, range_left, range_right, zero pad
	input  logic [((3*RANGE_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// action[1:0], turn_degrees[10:2], motor_speed[18:11], hold_ms[28:19], zero pad
	output logic [loas_pkg::OUT_W-1:0]      m_tdata,
	output logic                            m_tlast
);

	logic              push, full, empty, pop;
	loas_pkg::plan_t   plan, head;
	loas_pkg::act_t    out_act;
	logic signed [8:0] out_deg;
	logic [7:0]        out_spd;
	logic [9:0]        out_hold;

	assign cfg_ready = 1'b1;

	loas_front #(.RANGE_WIDTH(RANGE_WIDTH)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data),
		.in_valid     (s_tvalid),
		.range_middle (s_tdata[RANGE_WIDTH-1:0]),
		.range_left   (s_tdata[2*RANGE_WIDTH-1:RANGE_WIDTH]),
		.range_right  (s_tdata[3*RANGE_WIDTH-1:2*RANGE_WIDTH]),
		.full         (full),
		.in_ready     (s_tready),
		.push         (push),
		.plan         (plan)
	);

	loas_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_plan (plan),
		.pop       (pop),
		.full      (full),
		.empty     (empty),
		.head      (head)
	);

	loas_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.head      (head),
		.pop       (pop),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_act   (out_act),
		.out_deg   (out_deg),
		.out_spd   (out_spd),
		.out_hold  (out_hold),
		.out_last  (m_tlast)
	);

	// Pack the command
	assign m_tdata = {{loas_pkg::OUT_PAD{1'b0}}, out_hold, out_spd, out_deg, out_act};

	// Only turns carry an angle
	a_deg_turn_only: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] != loas_pkg::ACT_TURN) |-> (m_tdata[10:2] == 9'd0))
		else $error("turn angle on a non-turn command");

	// Only drives carry a speed
	a_spd_drive_only: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == loas_pkg::ACT_TURN || m_tdata[1:0] == loas_pkg::ACT_STOP)
		|-> (m_tdata[18:11] == 8'd0))
		else $error("motor speed on a turn or stop command");

	// Turns and forward drives hold zero time; a stop is never the last command
	a_hold_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == loas_pkg::ACT_TURN || m_tdata[1:0] == loas_pkg::ACT_FWD)
		|-> (m_tdata[28:19] == 10'd0))
		else $error("hold time on a turn or forward command");

	a_stop_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> (m_tdata[1:0] != loas_pkg::ACT_STOP))
		else $error("tick ended on a stop command");

endmodule
